### design/hds_pkg.sv
package hds_pkg;

	// Grid and number formats
	localparam int MAX_DIM    = 1024;
	localparam int LINE_DEPTH = MAX_DIM + 2;
	localparam int DIM_W      = 11;
	localparam int COL_W      = $clog2(LINE_DEPTH);
	localparam int CELL_W     = 32;
	localparam int COEF_W     = 16;
	localparam int FRAC_BITS  = 16;

	// Arithmetic widths: Laplacian term, product, truncated term, final sum
	localparam int LAP_W  = CELL_W + 3;
	localparam int PROD_W = LAP_W + COEF_W + 1;
	localparam int TERM_W = PROD_W - COEF_W;
	localparam int SUM_W  = TERM_W + 2;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_DIM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_X   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_Y   = 2'd2;

	localparam logic [DIM_W-1:0]  RESET_DIM  = 11'd64;
	localparam logic [COEF_W-1:0] RESET_COEF = 16'd6554;

	// Request queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Neighbourhood of one interior cell, as handed to the arithmetic
	typedef struct packed {
		logic signed [CELL_W-1:0] centre;
		logic signed [CELL_W-1:0] up;
		logic signed [CELL_W-1:0] down;
		logic signed [CELL_W-1:0] left;
		logic signed [CELL_W-1:0] right;
		logic                     last;
	} stencil_t;

	// Index of the last column/row of the haloed grid for a given interior size
	function automatic logic [DIM_W-1:0] dim_to_last(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] dc;
		if (d == '0) begin
			dc = DIM_W'(1);
		end else if (d > DIM_W'(MAX_DIM)) begin
			dc = DIM_W'(MAX_DIM);
		end else begin
			dc = d;
		end
		return dc + DIM_W'(1);
	endfunction

endpackage

### design/heat_diffusion_stencil_pass_top.sv
// A cell's result follows its lower-right neighbour via front s1, queue, back s1, s2, output.
// Throughput: one cell per cycle; the line buffers are a simple dual-port memory, read and
// written once a cycle. out_stall holds the back; in_stall rises on a request and full queue.
// Border and halo cells produce no result; every interior cell produces exactly one.
// Reset (arst_n low, asynchronous): counters, window and queue clear, grid_dim 64, coefs 6554;
// line buffers are not cleared, as they are only read in rows where nothing is emitted.
module heat_diffusion_stencil_pass_top import hds_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [CELL_W-1:0] cell_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [CELL_W-1:0] new_value,
	output logic                     last_cell
);

	logic [DIM_W-1:0]  last_idx_q;
	logic [COEF_W-1:0] coef_x_q;
	logic [COEF_W-1:0] coef_y_q;
	logic              restart;
	logic              push;
	logic              pop;
	logic              queue_full;
	logic              queue_avail;
	stencil_t          push_data;
	stencil_t          pop_data;

	assign restart = cfg_write && (cfg_index == REG_GRID_DIM);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_idx_q <= dim_to_last(RESET_DIM);
			coef_x_q   <= RESET_COEF;
			coef_y_q   <= RESET_COEF;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_GRID_DIM: last_idx_q <= dim_to_last(cfg_data[DIM_W-1:0]);
				REG_COEF_X:   coef_x_q   <= cfg_data[COEF_W-1:0];
				REG_COEF_Y:   coef_y_q   <= cfg_data[COEF_W-1:0];
				default:      ;
			endcase
		end
	end

	hds_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cell_value (cell_value),
		.last_idx   (last_idx_q),
		.restart    (restart),
		.queue_full (queue_full),
		.push       (push),
		.push_data  (push_data)
	);

	hds_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.avail     (queue_avail),
		.pop_data  (pop_data)
	);

	hds_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (queue_avail),
		.req       (pop_data),
		.pop       (pop),
		.coef_x    (coef_x_q),
		.coef_y    (coef_y_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.new_value (new_value),
		.last_cell (last_cell)
	);

endmodule

### design/hds_front.sv
module hds_front import hds_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [CELL_W-1:0] cell_value,
	input  logic [DIM_W-1:0]         last_idx,
	input  logic                     restart,
	input  logic                     queue_full,
	output logic                     push,
	output stencil_t                 push_data
);

	logic                     accept;
	logic                     s1_go;
	logic [COL_W-1:0]         row_q;
	logic [COL_W-1:0]         col_q;
	logic                     valid_s1;
	logic                     emit_s1;
	logic                     last_s1;
	logic [COL_W-1:0]         col_s1;
	logic signed [CELL_W-1:0] cell_s1;
	logic [2*CELL_W-1:0]      rd_s1;
	logic signed [CELL_W-1:0] above_q;
	logic signed [CELL_W-1:0] mid_left_q;
	logic signed [CELL_W-1:0] mid_q;
	logic signed [CELL_W-1:0] below_q;
	// Upper half: row above, lower half: middle row
	logic [2*CELL_W-1:0]      line_mem [LINE_DEPTH];

	// Stage one moves on unless it carries a request and the queue is full
	assign s1_go    = valid_s1 && (!emit_s1 || !queue_full);
	assign in_stall = valid_s1 && !s1_go;
	assign accept   = in_valid && !in_stall;

	// Raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_q == last_idx) begin
				col_q <= '0;
				row_q <= (row_q == last_idx) ? '0 : row_q + COL_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the cell and classify it
	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1 <= cell_value;
			col_s1  <= col_q;
			emit_s1 <= (row_q >= COL_W'(2)) && (col_q >= COL_W'(2));
			last_s1 <= (row_q == last_idx) && (col_q == last_idx);
		end
	end

	// Line buffers: read the column on accept, rotate it when stage one leaves
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= line_mem[col_q];
		end
		if (s1_go) begin
			line_mem[col_s1] <= {rd_s1[CELL_W-1:0], cell_s1};
		end
	end

	// Window columns to the left of the newest one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q    <= '0;
			mid_left_q <= '0;
			mid_q      <= '0;
			below_q    <= '0;
		end else if (s1_go) begin
			above_q    <= rd_s1[2*CELL_W-1:CELL_W];
			mid_left_q <= mid_q;
			mid_q      <= rd_s1[CELL_W-1:0];
			below_q    <= cell_s1;
		end
	end

	// Hand the neighbourhood of the cell one row up and one column left
	assign push             = s1_go && emit_s1;
	assign push_data.centre = mid_q;
	assign push_data.up     = above_q;
	assign push_data.down   = below_q;
	assign push_data.left   = mid_left_q;
	assign push_data.right  = rd_s1[CELL_W-1:0];
	assign push_data.last   = last_s1;

endmodule

### design/hds_queue.sv
module hds_queue import hds_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  stencil_t push_data,
	output logic     full,
	input  logic     pop,
	output logic     avail,
	output stencil_t pop_data
);

	stencil_t          store_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   count_q;

	assign full     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign avail    = (count_q != '0);
	assign pop_data = store_q[rd_q];

	// Write the entry
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

### design/hds_back.sv
module hds_back import hds_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     avail,
	input  stencil_t                 req,
	output logic                     pop,
	input  logic [COEF_W-1:0]        coef_x,
	input  logic [COEF_W-1:0]        coef_y,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [CELL_W-1:0] new_value,
	output logic                     last_cell
);

	logic                     en;
	logic                     valid_s1;
	logic                     valid_s2;
	logic                     out_valid_q;
	logic signed [CELL_W-1:0] ctr_s1;
	logic signed [CELL_W-1:0] ctr_s2;
	logic signed [LAP_W-1:0]  lap_v;
	logic signed [LAP_W-1:0]  lap_h;
	logic signed [LAP_W-1:0]  lapv_s1;
	logic signed [LAP_W-1:0]  laph_s1;
	logic                     last_s1;
	logic                     last_s2;
	logic signed [COEF_W:0]   cx;
	logic signed [COEF_W:0]   cy;
	logic signed [PROD_W-1:0] prod_x;
	logic signed [PROD_W-1:0] prod_y;
	logic signed [TERM_W-1:0] tx_s2;
	logic signed [TERM_W-1:0] ty_s2;
	logic signed [SUM_W-1:0]  sum;
	logic signed [CELL_W-1:0] sat;
	logic signed [CELL_W-1:0] new_value_q;
	logic                     last_q;

	// The whole pipe moves whenever the output register can take a result
	assign en  = !out_valid_q || !out_stall;
	assign pop = en && avail;

	// Stage one: second differences in both directions
	assign lap_v = LAP_W'(req.up) + LAP_W'(req.down) - (LAP_W'(req.centre) <<< 1);
	assign lap_h = LAP_W'(req.left) + LAP_W'(req.right) - (LAP_W'(req.centre) <<< 1);

	// Stage two: scale by the coefficients, drop the fraction (floor)
	assign cx     = {1'b0, coef_x};
	assign cy     = {1'b0, coef_y};
	assign prod_x = lapv_s1 * cx;
	assign prod_y = laph_s1 * cy;

	// Stage three: add to the centre and saturate
	assign sum = SUM_W'(ctr_s2) + SUM_W'(tx_s2) + SUM_W'(ty_s2);
	always_comb begin
		if (sum[SUM_W-1:CELL_W-1] == '0 || sum[SUM_W-1:CELL_W-1] == '1) begin
			sat = sum[CELL_W-1:0];
		end else if (sum[SUM_W-1]) begin
			sat = {1'b1, {(CELL_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(CELL_W-1){1'b1}}};
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= avail;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// Payload pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			ctr_s1      <= req.centre;
			lapv_s1     <= lap_v;
			laph_s1     <= lap_h;
			last_s1     <= req.last;
			ctr_s2      <= ctr_s1;
			tx_s2       <= prod_x[PROD_W-1:COEF_W];
			ty_s2       <= prod_y[PROD_W-1:COEF_W];
			last_s2     <= last_s1;
			new_value_q <= sat;
			last_q      <= last_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign new_value = new_value_q;
	assign last_cell = last_q;

endmodule
